// ----- src/srs_pkg.sv -----
// Shared types and codes for the shadow return stack.
// Holds the input and result word layouts and the operation, status, counter, configuration and mode codes.
// No dependencies.
`timescale 1ns / 1ps

package srs_pkg;

  localparam int TOP_W = 8;
  localparam int CNT_NUM = 6;

  localparam logic [3:0] OP_PUSH        = 4'd0;
  localparam logic [3:0] OP_POP_CHECKED = 4'd1;
  localparam logic [3:0] OP_POP_PLAIN   = 4'd2;
  localparam logic [3:0] OP_PEEK        = 4'd3;
  localparam logic [3:0] OP_UNWIND_DEP  = 4'd4;
  localparam logic [3:0] OP_UNWIND_ADR  = 4'd5;
  localparam logic [3:0] OP_CLEAR       = 4'd6;
  localparam logic [3:0] OP_READ_STAT   = 4'd7;
  localparam logic [3:0] OP_RESET_STAT  = 4'd8;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_OVERFLOW    = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW   = 3'd2;
  localparam logic [2:0] ST_REFUSED     = 3'd3;
  localparam logic [2:0] ST_CORRUPT     = 3'd4;
  localparam logic [2:0] ST_NOT_ENABLED = 3'd5;
  localparam logic [2:0] ST_BAD_PARAM   = 3'd6;

  localparam logic [2:0] CNT_PUSH     = 3'd0;
  localparam logic [2:0] CNT_POP      = 3'd1;
  localparam logic [2:0] CNT_OVER     = 3'd2;
  localparam logic [2:0] CNT_UNDER    = 3'd3;
  localparam logic [2:0] CNT_MISMATCH = 3'd4;
  localparam logic [2:0] CNT_CORRUPT  = 3'd5;
  localparam logic [2:0] SEL_DEEPEST  = 3'd6;

  localparam logic [1:0] CFG_ENABLED  = 2'd0;
  localparam logic [1:0] CFG_MODE     = 2'd1;
  localparam logic [1:0] CFG_CAPACITY = 2'd2;

  localparam logic [1:0] MODE_ENFORCE = 2'd2;

  typedef struct packed {
    logic [3:0]  op;
    logic [63:0] address;
    logic [7:0]  unwind_depth;
    logic [2:0]  stat_select;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] expected_address;
    logic        mismatch_seen;
    logic [7:0]  depth;
    logic [31:0] stat_value;
  } out_word_t;

endpackage

// ----- src/shadow_return_stack.sv -----
// Shadow return stack: return addresses in a one-port-read, one-port-write RAM.
// The result word is registered at the end of the execute state that follows the idle
// state in which its word is accepted; an unwind to an address stays in the execute
// state while it compares further entries below the topmost one. No new word is taken
// while one executes; the RAM read that precedes each update is issued in the idle state.
// Reset (synchronous, rst_n low) empties the stack, clears valid marks, statistics and config.
// Depends on srs_pkg.
`timescale 1ns / 1ps

module shadow_return_stack #(
  parameter int STACK_DEPTH = 128,
  parameter int ADDR_WIDTH  = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  srs_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output srs_pkg::out_word_t  out_word,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_wdata
);

  // Only the first min(STACK_DEPTH, 255) entries can ever hold data, since the
  // depth is an eight-bit value. Valid marks are kept in flip-flops for those alone.
  localparam int LIVE_DEPTH = (STACK_DEPTH > 255) ? 255 : STACK_DEPTH;
  localparam int IDX_W      = $clog2(STACK_DEPTH);
  localparam int VIDX_W     = $clog2(LIVE_DEPTH);
  localparam int TW         = srs_pkg::TOP_W;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                  state_r, state_nxt;
  srs_pkg::in_word_t       item_r;
  logic [TW-1:0]           cur_r, cur_nxt;
  logic [TW-1:0]           top_r, top_nxt;
  logic [LIVE_DEPTH-1:0]   valid_r, valid_nxt;
  logic [31:0]             cnt_r   [srs_pkg::CNT_NUM];
  logic [31:0]             cnt_nxt [srs_pkg::CNT_NUM];
  logic [TW-1:0]           deepest_r, deepest_nxt;
  logic                    enabled_r;
  logic [1:0]              mode_r;
  logic [7:0]              cap_r;
  logic                    out_valid_r, out_valid_nxt;
  srs_pkg::out_word_t      out_word_r, out_word_nxt;

  // Stack storage. Entries below the top are always written before they are
  // read, so the RAM needs no clearing; discarding an entry drops its valid mark.
  logic [ADDR_WIDTH-1:0]   slot_mem_r [STACK_DEPTH];
  logic [ADDR_WIDTH-1:0]   rdata_r;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  logic [ADDR_WIDTH-1:0]   mem_wdata;

  logic                    accept;
  logic [ADDR_WIDTH-1:0]   item_addr;
  logic [TW-1:0]           cap_live;
  logic                    done;
  logic                    cut_en;
  logic [TW-1:0]           cut_lo;

  // A new word is taken only when idle and when the result register is empty or
  // being emptied at this edge, so the result of that word always finds room.
  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign item_addr = item_r.address[ADDR_WIDTH-1:0];

  // A capacity of zero, or one above the usable depth, means the full usable depth.
  always_comb begin
    if (cap_r == 8'd0 || int'(cap_r) > LIVE_DEPTH) begin
      cap_live = TW'(LIVE_DEPTH);
    end else begin
      cap_live = cap_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    top_nxt       = top_r;
    valid_nxt     = valid_r;
    deepest_nxt   = deepest_r;
    for (int k = 0; k < srs_pkg::CNT_NUM; k++) begin
      cnt_nxt[k] = cnt_r[k];
    end
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_waddr     = IDX_W'(top_r);
    mem_wdata     = item_addr;
    done          = 1'b1;
    cut_en        = 1'b0;
    cut_lo        = top_r;

    if (state_r == S_IDLE) begin
      // The entry just below the top is read for every operation; the search
      // for an address starts there too.
      cur_nxt = top_r - TW'(1);
      if (accept) begin
        state_nxt = S_EXEC;
      end
    end else begin
      out_word_nxt = '0;
      out_word_nxt.status = srs_pkg::ST_OK;
      case (item_r.op)
        srs_pkg::OP_PUSH: begin
          if (!enabled_r) begin
            out_word_nxt.status = srs_pkg::ST_NOT_ENABLED;
          end else if (top_r >= cap_live) begin
            cnt_nxt[srs_pkg::CNT_OVER] = cnt_r[srs_pkg::CNT_OVER] + 32'd1;
            out_word_nxt.status = srs_pkg::ST_OVERFLOW;
          end else begin
            mem_we = 1'b1;
            valid_nxt[VIDX_W'(top_r)] = 1'b1;
            top_nxt = top_r + TW'(1);
            cnt_nxt[srs_pkg::CNT_PUSH] = cnt_r[srs_pkg::CNT_PUSH] + 32'd1;
            if (top_r + TW'(1) > deepest_r) begin
              deepest_nxt = top_r + TW'(1);
            end
          end
        end
        srs_pkg::OP_POP_CHECKED, srs_pkg::OP_POP_PLAIN: begin
          if (!enabled_r) begin
            out_word_nxt.status = srs_pkg::ST_NOT_ENABLED;
          end else if (top_r == '0) begin
            cnt_nxt[srs_pkg::CNT_UNDER] = cnt_r[srs_pkg::CNT_UNDER] + 32'd1;
            out_word_nxt.status = srs_pkg::ST_UNDERFLOW;
          end else begin
            top_nxt = cur_r;
            cnt_nxt[srs_pkg::CNT_POP] = cnt_r[srs_pkg::CNT_POP] + 32'd1;
            if (item_r.op == srs_pkg::OP_POP_PLAIN) begin
              out_word_nxt.expected_address = 64'(rdata_r);
              valid_nxt[VIDX_W'(cur_r)] = 1'b0;
            end else if (!valid_r[VIDX_W'(cur_r)]) begin
              cnt_nxt[srs_pkg::CNT_CORRUPT] = cnt_r[srs_pkg::CNT_CORRUPT] + 32'd1;
              out_word_nxt.status = srs_pkg::ST_CORRUPT;
            end else begin
              out_word_nxt.expected_address = 64'(rdata_r);
              if (rdata_r != item_addr) begin
                out_word_nxt.mismatch_seen = 1'b1;
                cnt_nxt[srs_pkg::CNT_MISMATCH] = cnt_r[srs_pkg::CNT_MISMATCH] + 32'd1;
              end
              // In enforce mode (and the unused fourth mode) a mismatch keeps the entry's valid mark.
              if (rdata_r != item_addr && mode_r >= srs_pkg::MODE_ENFORCE) begin
                out_word_nxt.status = srs_pkg::ST_REFUSED;
              end else begin
                valid_nxt[VIDX_W'(cur_r)] = 1'b0;
              end
            end
          end
        end
        srs_pkg::OP_PEEK: begin
          if (!enabled_r) begin
            out_word_nxt.status = srs_pkg::ST_NOT_ENABLED;
          end else if (top_r == '0) begin
            out_word_nxt.status = srs_pkg::ST_UNDERFLOW;
          end else begin
            out_word_nxt.expected_address = 64'(rdata_r);
          end
        end
        srs_pkg::OP_UNWIND_DEP: begin
          if (item_r.unwind_depth > top_r) begin
            out_word_nxt.status = srs_pkg::ST_BAD_PARAM;
          end else begin
            cut_en  = 1'b1;
            cut_lo  = item_r.unwind_depth;
            top_nxt = item_r.unwind_depth;
          end
        end
        srs_pkg::OP_UNWIND_ADR: begin
          // One entry is compared per cycle, walking down from the top; the
          // RAM read of the next entry is issued while this one is compared.
          if (item_addr == '0 || top_r == '0) begin
            out_word_nxt.status = srs_pkg::ST_BAD_PARAM;
          end else if (rdata_r == item_addr) begin
            cut_en  = 1'b1;
            cut_lo  = cur_r + TW'(1);
            top_nxt = cur_r + TW'(1);
          end else if (cur_r == '0) begin
            out_word_nxt.status = srs_pkg::ST_BAD_PARAM;
          end else begin
            done    = 1'b0;
            cur_nxt = cur_r - TW'(1);
          end
        end
        srs_pkg::OP_CLEAR: begin
          valid_nxt = '0;
          top_nxt   = '0;
        end
        srs_pkg::OP_READ_STAT: begin
          if (item_r.stat_select < srs_pkg::SEL_DEEPEST) begin
            out_word_nxt.stat_value = cnt_r[item_r.stat_select];
          end else if (item_r.stat_select == srs_pkg::SEL_DEEPEST) begin
            out_word_nxt.stat_value = 32'(deepest_r);
          end else begin
            out_word_nxt.status = srs_pkg::ST_BAD_PARAM;
          end
        end
        srs_pkg::OP_RESET_STAT: begin
          for (int k = 0; k < srs_pkg::CNT_NUM; k++) begin
            cnt_nxt[k] = '0;
          end
          deepest_nxt = '0;
        end
        default: begin
          out_word_nxt.status = srs_pkg::ST_BAD_PARAM;
        end
      endcase

      // Unwinding drops the valid marks of every entry from the new top upwards.
      if (cut_en) begin
        for (int j = 0; j < LIVE_DEPTH; j++) begin
          if (j >= int'(cut_lo) && j < int'(top_r)) begin
            valid_nxt[j] = 1'b0;
          end
        end
      end

      out_word_nxt.depth = top_nxt;
      if (done) begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end else begin
        out_word_nxt = out_word_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      valid_r     <= '0;
      deepest_r   <= '0;
      for (int k = 0; k < srs_pkg::CNT_NUM; k++) begin
        cnt_r[k] <= '0;
      end
      enabled_r   <= 1'b0;
      mode_r      <= 2'd0;
      cap_r       <= 8'd128;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      valid_r     <= valid_nxt;
      deepest_r   <= deepest_nxt;
      for (int k = 0; k < srs_pkg::CNT_NUM; k++) begin
        cnt_r[k] <= cnt_nxt[k];
      end
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          srs_pkg::CFG_ENABLED:  enabled_r <= cfg_wdata[0];
          srs_pkg::CFG_MODE:     mode_r    <= cfg_wdata[1:0];
          srs_pkg::CFG_CAPACITY: cap_r     <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
    cur_r      <= cur_nxt;
    out_word_r <= out_word_nxt;
    if (accept) begin
      item_r <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem_r[mem_waddr] <= mem_wdata;
    end
    rdata_r <= slot_mem_r[IDX_W'(cur_nxt)];
  end

  // A result appears only as the end of an operation being executed.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result raised without an executing operation");

  // The depth never runs past the usable part of the stack.
  assert property (@(posedge clk) disable iff (!rst_n)
    int'(top_r) <= LIVE_DEPTH)
    else $error("stack depth beyond usable entries");

  // A successful push grows the stack by exactly one entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && item_r.op == srs_pkg::OP_PUSH && enabled_r && top_r < cap_live)
    |=> top_r == $past(top_r) + TW'(1))
    else $error("push did not advance the top");

  // A mismatch is only ever reported with an allowed or a refused pop.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.mismatch_seen) |->
      (out_word_r.status == srs_pkg::ST_OK || out_word_r.status == srs_pkg::ST_REFUSED))
    else $error("mismatch reported with a wrong status");

  // While an operation executes, no new word is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> !accept)
    else $error("word accepted during execution");

endmodule
